// ===== rtl/tllpq_pkg.sv =====
`timescale 1ns / 1ps
package tllpq_pkg;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEVEL_W  = 5;

  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'd65;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'd90;
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'd0;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOT_LETTER,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_UPPER,
    SRC_LOWER
  } src_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DELIVER
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } stat_t;

endpackage

// ===== rtl/tllpq_if.sv =====
`timescale 1ns / 1ps
interface tllpq_in_if import tllpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output mode, output char_in, input ready);
  modport sink   (input valid, input mode, input char_in, output ready);
endinterface

interface tllpq_out_if import tllpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   char_out;
  logic [STATUS_W-1:0] status;
  logic [LEVEL_W-1:0]  upper_level;
  logic [LEVEL_W-1:0]  lower_level;

  modport source (output valid, output char_out, output status, output upper_level,
                  output lower_level, input ready);
  modport sink   (input valid, input char_out, input status, input upper_level,
                  input lower_level, output ready);
endinterface

// ===== rtl/tllpq_ctrl.sv =====
`timescale 1ns / 1ps
module tllpq_ctrl import tllpq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DELIVER;
      end
      S_DELIVER: begin
        if (stat.slot_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.exec    = (state == S_EXEC);
    cmd.load    = (state == S_DELIVER) && stat.slot_free;
  end

`ifndef ASSERT_OFF
  a_exec_follows_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec)
    else $error("execute step did not follow a transfer");
  a_no_capture_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.capture)
    else $error("input captured while an item is in flight");
`endif

endmodule

// ===== rtl/tllpq_dp.sv =====
`timescale 1ns / 1ps
module tllpq_dp import tllpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                mode,
  input  logic [CHAR_W-1:0]   char_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   char_out,
  output logic [STATUS_W-1:0] status,
  output logic [LEVEL_W-1:0]  upper_level,
  output logic [LEVEL_W-1:0]  lower_level
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic [CHAR_W-1:0] upper_mem [QUEUE_DEPTH];
  logic [CHAR_W-1:0] lower_mem [QUEUE_DEPTH];
  logic [CHAR_W-1:0] upper_rd;
  logic [CHAR_W-1:0] lower_rd;

  logic              mode_q;
  logic [CHAR_W-1:0] char_q;

  logic [IDX_W-1:0] upper_head, upper_head_next;
  logic [IDX_W-1:0] lower_head, lower_head_next;
  logic [CNT_W-1:0] upper_count, upper_count_next;
  logic [CNT_W-1:0] lower_count, lower_count_next;
  status_t          res_status, res_status_next;
  src_t             res_src, res_src_next;

  logic             is_upper, is_lower;
  logic             upper_we, lower_we, upper_re, lower_re;
  logic [IDX_W:0]   upper_sum, lower_sum;
  logic [IDX_W-1:0] upper_tail, lower_tail;
  logic [EXT_W-1:0] upper_ext, lower_ext;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      char_q <= char_in;
    end
  end

  always_comb begin
    is_upper  = (char_q >= UPPER_FIRST) && (char_q <= UPPER_LAST);
    is_lower  = (char_q >= LOWER_FIRST) && (char_q <= LOWER_LAST);
    upper_sum = {1'b0, upper_head} + (IDX_W + 1)'(upper_count);
    lower_sum = {1'b0, lower_head} + (IDX_W + 1)'(lower_count);
    upper_tail = (upper_sum >= DEPTH_X) ? IDX_W'(upper_sum - DEPTH_X) : upper_sum[IDX_W-1:0];
    lower_tail = (lower_sum >= DEPTH_X) ? IDX_W'(lower_sum - DEPTH_X) : lower_sum[IDX_W-1:0];
  end

  always_comb begin
    upper_head_next  = upper_head;
    lower_head_next  = lower_head;
    upper_count_next = upper_count;
    lower_count_next = lower_count;
    res_status_next  = res_status;
    res_src_next     = res_src;
    upper_we = 1'b0;
    lower_we = 1'b0;
    upper_re = 1'b0;
    lower_re = 1'b0;
    if (cmd.exec) begin
      res_status_next = ST_OK;
      res_src_next    = SRC_NONE;
      if (mode_q == MODE_ENQ) begin
        priority if (is_upper) begin
          if (upper_count == FULL_CNT) begin
            res_status_next = ST_FULL;
          end else begin
            upper_we         = 1'b1;
            upper_count_next = upper_count + 1'b1;
          end
        end else if (is_lower) begin
          if (lower_count == FULL_CNT) begin
            res_status_next = ST_FULL;
          end else begin
            lower_we         = 1'b1;
            lower_count_next = lower_count + 1'b1;
          end
        end else begin
          res_status_next = ST_NOT_LETTER;
        end
      end else begin
        priority if (upper_count != '0) begin
          upper_re         = 1'b1;
          res_src_next     = SRC_UPPER;
          upper_count_next = upper_count - 1'b1;
          upper_head_next  = (upper_head == LAST_IDX) ? '0 : upper_head + 1'b1;
        end else if (lower_count != '0) begin
          lower_re         = 1'b1;
          res_src_next     = SRC_LOWER;
          lower_count_next = lower_count - 1'b1;
          lower_head_next  = (lower_head == LAST_IDX) ? '0 : lower_head + 1'b1;
        end else begin
          res_status_next = ST_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_head  <= '0;
      lower_head  <= '0;
      upper_count <= '0;
      lower_count <= '0;
      res_status  <= ST_OK;
      res_src     <= SRC_NONE;
    end else begin
      upper_head  <= upper_head_next;
      lower_head  <= lower_head_next;
      upper_count <= upper_count_next;
      lower_count <= lower_count_next;
      res_status  <= res_status_next;
      res_src     <= res_src_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upper_we) upper_mem[upper_tail] <= char_q;
    if (upper_re) upper_rd <= upper_mem[upper_head];
  end

  always_ff @(posedge clk) begin
    if (lower_we) lower_mem[lower_tail] <= char_q;
    if (lower_re) lower_rd <= lower_mem[lower_head];
  end

  assign stat.slot_free = !out_valid || out_ready;
  assign upper_ext = EXT_W'(upper_count);
  assign lower_ext = EXT_W'(lower_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (res_src)
        SRC_UPPER: char_out <= upper_rd;
        SRC_LOWER: char_out <= lower_rd;
        default:   char_out <= CHAR_NONE;
      endcase
      status      <= res_status;
      upper_level <= upper_ext[LEVEL_W-1:0];
      lower_level <= lower_ext[LEVEL_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (upper_count <= FULL_CNT) && (lower_count <= FULL_CNT))
    else $error("queue count beyond depth");
  a_dequeue_upper_first: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && mode_q == MODE_DEQ && upper_count != '0) |=>
      (upper_count == $past(upper_count) - 1'b1) && (lower_count == $past(lower_count)))
    else $error("dequeue did not take from the high-priority queue");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && mode_q == MODE_ENQ && is_upper && upper_count == FULL_CNT) |=>
      $stable(upper_count) && res_status == ST_FULL)
    else $error("enqueue into full queue was not dropped");
  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> stat.slot_free)
    else $error("result loaded over a pending transfer");
`endif

endmodule

// ===== rtl/two_level_letter_priority_queue.sv =====
// Flow: an input transfer is followed by the execute step and then the deliver step,
//   which loads the result once the output slot is free. A new item is taken only
//   after the last one is loaded; capture, execute and deliver run in turn, and a
//   dequeue's registered store read lands in execute, so deliver picks it up free.
// Reset (rst, synchronous, active high) clears both queues' heads and counts and the
//   output valid; the stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module two_level_letter_priority_queue import tllpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  tllpq_in_if.sink    in_ch,
  tllpq_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  tllpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tllpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (in_ch.mode),
    .char_in     (in_ch.char_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .char_out    (out_ch.char_out),
    .status      (out_ch.status),
    .upper_level (out_ch.upper_level),
    .lower_level (out_ch.lower_level)
  );

endmodule
